/* hdl/hsd_pkg.sv */
// ----------------------------------------------------------------------------
// hsd_pkg
// shared types and constants for the hash to share difficulty core
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int HASH_W   = 256;
    localparam int WORD_W   = 64;
    localparam int LZ_W     = 8;
    localparam int TOP_W    = 9;
    localparam int MANT_W   = 53;
    localparam int REM_W    = MANT_W + 1;
    localparam int QUOT_W   = 56;
    localparam int EXP_W    = 11;
    localparam int FRAC_W   = 52;

    // 0xffff scaled to a 53-bit mantissa
    localparam logic [MANT_W-1:0] DIFF_ONE_MANT = MANT_W'(64'hFFFF << 37);
    // biased exponent of diff_one (2^223) plus bias, before subtracting the hash exponent
    localparam logic [11:0] EXP_BASE = 12'd1246;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_INF  = 2'd2;

    typedef struct packed {
        logic              zero;
        logic [HASH_W-1:0] v;
        logic [LZ_W-1:0]   lz;
    } norm_t;

    typedef struct packed {
        logic              zero;
        logic [TOP_W-1:0]  top;
        logic [REM_W-1:0]  r;
        logic [MANT_W-1:0] d;
        logic [QUOT_W-1:0] q;
    } div_t;

endpackage

/* hdl/hash_to_share_difficulty_core.sv */
// ----------------------------------------------------------------------------
// hash_to_share_difficulty_core
// share difficulty of a 256-bit hash as an IEEE-754 double
// ----------------------------------------------------------------------------
// Accepts one hash per cycle while s_ready is high and returns one result per
// hash, in order. The path has eight normalizer stages, one rounding stage, a
// chain of 56 division cells that each produce one quotient bit, and a
// combinational final rounding into the output register. A skid stage behind
// it holds one result while m_ready is low; while it is full, s_ready is low
// and the pipeline stalls. A zero hash returns quiet NaN with status 1.
module hash_to_share_difficulty_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_hash_word0,
    input  logic [63:0] s_hash_word1,
    input  logic [63:0] s_hash_word2,
    input  logic [63:0] s_hash_word3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_difficulty_bits,
    output logic [1:0]  m_result_status
);
    import hsd_pkg::*;

    logic en;
    logic norm_vld;
    norm_t norm_out;

    logic prep_valid_reg;
    div_t prep_reg;
    div_t prep_next;

    logic [QUOT_W:0] div_vld;
    div_t            div_d [0:QUOT_W];

    logic [MANT_W-1:0] rm;
    logic              rinc;
    logic [MANT_W:0]   rsum;

    logic              hi;
    logic [MANT_W-1:0] mant;
    logic              grd;
    logic              sticky;
    logic              inc;
    logic [MANT_W:0]   msum;
    logic [11:0]       expw;
    logic [63:0]       res_bits;
    logic [1:0]        res_status;

    logic        out_valid_reg;
    logic [63:0] out_bits_reg;
    logic [1:0]  out_status_reg;
    logic        skid_valid_reg;
    logic [63:0] skid_bits_reg;
    logic [1:0]  skid_status_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    hsd_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_hash   ({s_hash_word3, s_hash_word2, s_hash_word1, s_hash_word0}),
        .out_valid (norm_vld),
        .out_data  (norm_out)
    );

    // round the normalized hash to 53 bits
    always_comb begin
        rm   = norm_out.v[HASH_W-1 -: MANT_W];
        rinc = norm_out.v[HASH_W-MANT_W-1]
             & ((|norm_out.v[HASH_W-MANT_W-2:0]) | rm[0]);
        rsum = {1'b0, rm} + {{MANT_W{1'b0}}, rinc};
        prep_next.zero = norm_out.zero;
        prep_next.top  = TOP_W'(255) - {1'b0, norm_out.lz} + {{(TOP_W-1){1'b0}}, rsum[MANT_W]};
        prep_next.d    = rsum[MANT_W] ? rsum[MANT_W:1] : rsum[MANT_W-1:0];
        prep_next.r    = {1'b0, DIFF_ONE_MANT};
        prep_next.q    = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= norm_vld;
        end
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign div_vld[0] = prep_valid_reg;
    assign div_d[0]   = prep_reg;

    for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
        hsd_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_vld[k]),
            .in_data   (div_d[k]),
            .out_valid (div_vld[k+1]),
            .out_data  (div_d[k+1])
        );
    end

    // final rounding of the quotient
    always_comb begin
        hi     = div_d[QUOT_W].q[QUOT_W-1];
        mant   = hi ? div_d[QUOT_W].q[QUOT_W-1:3] : div_d[QUOT_W].q[QUOT_W-2:2];
        grd    = hi ? div_d[QUOT_W].q[2] : div_d[QUOT_W].q[1];
        sticky = (hi ? (|div_d[QUOT_W].q[1:0]) : div_d[QUOT_W].q[0])
               | (div_d[QUOT_W].r != '0);
        inc    = grd & (sticky | mant[0]);
        msum   = {1'b0, mant} + {{MANT_W{1'b0}}, inc};
        expw   = EXP_BASE - {3'b0, div_d[QUOT_W].top} - {11'b0, !hi}
               + {11'b0, msum[MANT_W]};
        if (div_d[QUOT_W].zero) begin
            res_bits   = QNAN_BITS;
            res_status = STATUS_ZERO;
        end else begin
            res_bits   = {1'b0, expw[EXP_W-1:0],
                          msum[MANT_W] ? {FRAC_W{1'b0}} : msum[FRAC_W-1:0]};
            res_status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                out_bits_reg   <= skid_bits_reg;
                out_status_reg <= skid_status_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg  <= div_vld[QUOT_W];
            out_bits_reg   <= res_bits;
            out_status_reg <= res_status;
        end else if (div_vld[QUOT_W]) begin
            skid_valid_reg  <= 1'b1;
            skid_bits_reg   <= res_bits;
            skid_status_reg <= res_status;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_difficulty_bits = out_bits_reg;
    assign m_result_status   = out_status_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_no_inf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_status != STATUS_INF))
        else $error("infinite result from an integer hash");

    a_zero_nan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_status == STATUS_ZERO)) |-> (m_difficulty_bits == QNAN_BITS))
        else $error("zero hash status without quiet nan");

    a_ok_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_status == STATUS_OK)) |->
        ((m_difficulty_bits[62:52] != 11'h000) && (m_difficulty_bits[62:52] != 11'h7FF)))
        else $error("valid result is not a normal number");

endmodule

/* hdl/hsd_norm.sv */
// ----------------------------------------------------------------------------
// hsd_norm
// eight-stage leading-zero normalizer for the 256-bit hash
// ----------------------------------------------------------------------------
module hsd_norm (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [hsd_pkg::HASH_W-1:0]  in_hash,
    output logic                        out_valid,
    output hsd_pkg::norm_t              out_data
);
    import hsd_pkg::*;

    logic  [8:1] vld_reg;
    norm_t       st_reg [1:8];

    for (genvar k = 0; k < 8; k++) begin : g_stage
        localparam int S = 128 >> k;
        norm_t cur;
        logic  cur_vld;
        norm_t st_next;

        if (k == 0) begin : g_first
            always_comb begin
                cur.zero = (in_hash == '0);
                cur.v    = in_hash;
                cur.lz   = '0;
                cur_vld  = in_valid;
            end
        end else begin : g_rest
            always_comb begin
                cur     = st_reg[k];
                cur_vld = vld_reg[k];
            end
        end

        always_comb begin
            st_next = cur;
            if (cur.v[HASH_W-1 -: S] == '0) begin
                st_next.v  = cur.v << S;
                st_next.lz = cur.lz + LZ_W'(S);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= cur_vld;
            end
            if (en) begin
                st_reg[k+1] <= st_next;
            end
        end
    end

    assign out_valid = vld_reg[8];
    assign out_data  = st_reg[8];

endmodule

/* hdl/hsd_div_cell.sv */
// ----------------------------------------------------------------------------
// hsd_div_cell
// one restoring-division cell: one quotient bit per cell
// ----------------------------------------------------------------------------
module hsd_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  hsd_pkg::div_t in_data,
    output logic          out_valid,
    output hsd_pkg::div_t out_data
);
    import hsd_pkg::*;

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic             ge;
    logic [REM_W-1:0] diff;
    logic [REM_W-1:0] rn;

    always_comb begin
        ge        = (in_data.r >= {1'b0, in_data.d});
        diff      = in_data.r - {1'b0, in_data.d};
        rn        = ge ? diff : in_data.r;
        data_next = in_data;
        data_next.r = {rn[REM_W-2:0], 1'b0};
        data_next.q = {in_data.q[QUOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
